/* src/cbrf_pkg.sv */
// shared constants, operand codes and threshold function for the cubic bisection root finder
package cbrf_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int TOL_WIDTH      = 31;

    localparam logic [1:0] OP_LEFT  = 2'd0;
    localparam logic [1:0] OP_RIGHT = 2'd1;
    localparam logic [1:0] OP_MID   = 2'd2;

    // largest raw value whose cubic is negative, clamped to the positive range
    function automatic logic [63:0] root_threshold(input int frac_bits, input int data_width);
        logic signed [127:0] scale;
        logic signed [127:0] lo;
        logic signed [127:0] hi;
        logic signed [127:0] mid;
        logic signed [127:0] poly;
        logic signed [127:0] lim;
        int                  i;
        scale = 128'sd1 <<< frac_bits;
        lo    = scale * 128'sd2;
        hi    = scale * 128'sd3;
        for (i = 0; i < 40; i++)
        begin
            if (hi - lo > 128'sd1)
            begin
                mid  = (lo + hi) >>> 1;
                poly = mid * mid * mid - 128'sd2 * mid * scale * scale
                       - 128'sd5 * scale * scale * scale;
                if (poly < 128'sd0)
                begin
                    lo = mid;
                end
                else
                begin
                    hi = mid;
                end
            end
        end
        lim = (128'sd1 <<< (data_width - 1)) - 128'sd1;
        if (lo > lim)
        begin
            lo = lim;
        end
        return lo[63:0];
    endfunction

endpackage

/* src/cubic_bisection_root_finder_unit.sv */
// top level of the cubic bisection root finder
// One transaction in, one out. The block finds a root of x^3 - 2x - 5 on [left_end, right_end]
// by bisection in signed fixed point. After the input is taken the sign of the cubic is checked
// at both ends, then each halving is done in the shared evaluation unit, a further step of the
// search detects the stop width and the finish state loads the output register. The number of
// halvings is at most DATA_WIDTH, 32 for 32 bits. Without a sign change no halving is done.
// The input is not ready while a search runs; a finished result waits in the output register,
// and the next one waits until it is taken.
// Status 1 means no sign change at the ends, with root 0; within tolerance at the start, the
// left end comes back. A tolerance of zero acts as one lsb.
module cubic_bisection_root_finder_unit #(
    parameter int DATA_WIDTH = cbrf_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = cbrf_pkg::FRAC_BITS_DEF
) (
    input  logic                                                     clk,
    input  logic                                                     rst_n,
    input  logic                                                     s_axis_tvalid,
    output logic                                                     s_axis_tready,
    // left_end, right_end, tolerance
    input  logic [((2*DATA_WIDTH+cbrf_pkg::TOL_WIDTH+7)/8)*8-1:0]   s_axis_tdata,
    output logic                                                     m_axis_tvalid,
    input  logic                                                     m_axis_tready,
    // root
    output logic [((DATA_WIDTH+7)/8)*8-1:0]                          m_axis_tdata,
    // status
    output logic                                                     m_axis_tuser
);
    import cbrf_pkg::*;

    localparam int OUT_W = ((DATA_WIDTH + 7) / 8) * 8;
    localparam int CW    = (DATA_WIDTH + 1 > TOL_WIDTH + 1) ? DATA_WIDTH + 1 : TOL_WIDTH + 1;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EVAL_A = 3'd1;
    localparam logic [2:0] S_EVAL_B = 3'd2;
    localparam logic [2:0] S_ITER   = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;

    logic [2:0]                   state_reg, state_next;
    logic signed [DATA_WIDTH-1:0] a_reg, a_next;
    logic signed [DATA_WIDTH-1:0] b_reg, b_next;
    logic signed [DATA_WIDTH-1:0] c_reg, c_next;
    logic [TOL_WIDTH-1:0]         tol_reg, tol_next;
    logic                         fa_reg, fa_next;
    logic                         status_reg, status_next;
    logic [DATA_WIDTH-1:0]        out_root_reg, out_root_next;
    logic                         out_status_reg, out_status_next;
    logic                         out_valid_reg, out_valid_next;

    logic [1:0]                   op;
    logic signed [DATA_WIDTH-1:0] mid;
    logic                         positive;
    logic signed [DATA_WIDTH:0]   width;
    logic signed [CW-1:0]         width_ext;
    logic signed [CW-1:0]         tol_ext;
    logic [TOL_WIDTH-1:0]         in_tol;
    logic                         in_fire;
    logic                         out_free;

    cbrf_eval_unit #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_eval (
        .op        (op),
        .left_val  (a_reg),
        .right_val (b_reg),
        .mid       (mid),
        .positive  (positive)
    );

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign in_tol        = s_axis_tdata[2*DATA_WIDTH +: TOL_WIDTH];

    assign width     = {b_reg[DATA_WIDTH-1], b_reg} - {a_reg[DATA_WIDTH-1], a_reg};
    assign width_ext = CW'(width);
    assign tol_ext   = CW'($signed({1'b0, tol_reg}));

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_W'(out_root_reg);
    assign m_axis_tuser  = out_status_reg;

    always_comb
    begin
        state_next      = state_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        c_next          = c_reg;
        tol_next        = tol_reg;
        fa_next         = fa_reg;
        status_next     = status_reg;
        out_root_next   = out_root_reg;
        out_status_next = out_status_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        op              = OP_MID;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    a_next      = $signed(s_axis_tdata[DATA_WIDTH-1:0]);
                    b_next      = $signed(s_axis_tdata[2*DATA_WIDTH-1:DATA_WIDTH]);
                    c_next      = $signed(s_axis_tdata[DATA_WIDTH-1:0]);
                    tol_next    = (in_tol == '0) ? TOL_WIDTH'(1) : in_tol;
                    status_next = 1'b0;
                    state_next  = S_EVAL_A;
                end
            end
            S_EVAL_A:
            begin
                op         = OP_LEFT;
                fa_next    = positive;
                state_next = S_EVAL_B;
            end
            S_EVAL_B:
            begin
                op = OP_RIGHT;
                if (positive == fa_reg)
                begin
                    status_next = 1'b1;
                    c_next      = '0;
                    state_next  = S_FINISH;
                end
                else
                begin
                    state_next = S_ITER;
                end
            end
            S_ITER:
            begin
                op = OP_MID;
                if (width_ext > tol_ext)
                begin
                    c_next = mid;
                    if (positive != fa_reg)
                    begin
                        b_next = mid;
                    end
                    else
                    begin
                        a_next = mid;
                    end
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    out_root_next   = c_reg;
                    out_status_next = status_reg;
                    out_valid_next  = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg          <= a_next;
        b_reg          <= b_next;
        c_reg          <= c_next;
        tol_reg        <= tol_next;
        fa_reg         <= fa_next;
        status_reg     <= status_next;
        out_root_reg   <= out_root_next;
        out_status_reg <= out_status_next;
    end

endmodule

/* src/cbrf_eval_unit.sv */
// shared evaluation unit: midpoint adder and sign test of the cubic
module cbrf_eval_unit #(
    parameter int DATA_WIDTH = cbrf_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = cbrf_pkg::FRAC_BITS_DEF
) (
    input  logic [1:0]                   op,
    input  logic signed [DATA_WIDTH-1:0] left_val,
    input  logic signed [DATA_WIDTH-1:0] right_val,
    output logic signed [DATA_WIDTH-1:0] mid,
    output logic                         positive
);
    import cbrf_pkg::*;

    localparam logic [63:0] THRESH_FULL = root_threshold(FRAC_BITS, DATA_WIDTH);
    localparam logic signed [DATA_WIDTH-1:0] THRESH = THRESH_FULL[DATA_WIDTH-1:0];

    logic signed [DATA_WIDTH:0]   sum;
    logic signed [DATA_WIDTH-1:0] operand;

    assign sum = {left_val[DATA_WIDTH-1], left_val} + {right_val[DATA_WIDTH-1], right_val};
    assign mid = sum[DATA_WIDTH:1];

    always_comb
    begin
        unique case (op)
            OP_LEFT:  operand = left_val;
            OP_RIGHT: operand = right_val;
            default:  operand = mid;
        endcase
    end

    // single real root is irrational, so the cubic is never zero on the grid
    assign positive = (operand > THRESH);

endmodule

/* tb/cubic_bisection_root_finder_checker.sv */
// checker for the cubic bisection root finder: predicts each root and compares results
`timescale 1ns / 1ps

module cubic_bisection_root_finder_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    // left_end, right_end, tolerance
    input  logic [95:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // root
    input  logic [31:0] m_axis_tdata,
    // status
    input  logic        m_axis_tuser,
    output int          mismatch_count,
    output int          roots_pending
);

    typedef struct packed {
        logic [31:0] root;
        logic        status;
    } root_result_t;

    root_result_t expected_roots[$];
    root_result_t want;

    initial
    begin
        mismatch_count = 0;
        roots_pending  = 0;
    end

    // sign of x^3 - 2x - 5 at raw q16.16 point x, scaled by 2^48 so it stays exact
    function automatic int cubic_sign(input longint x);
        logic signed [127:0] xv;
        logic signed [127:0] n;
        xv = x;
        n  = xv * xv * xv - (xv <<< 33) - (128'sd5 <<< 48);
        if (n < 0)
        begin
            return -1;
        end
        return (n == 0) ? 0 : 1;
    endfunction

    function automatic root_result_t bisect_root(input logic [95:0] item);
        root_result_t res;
        longint       lo;
        longint       hi;
        longint       mid;
        longint       tol;
        int           s_lo;
        int           s_hi;
        int           s_mid;
        logic         hit;
        lo  = longint'(signed'(item[31:0]));
        hi  = longint'(signed'(item[63:32]));
        tol = longint'({33'd0, item[94:64]});
        if (tol == 0)
        begin
            tol = 1;
        end
        s_lo = cubic_sign(lo);
        s_hi = cubic_sign(hi);
        if (s_lo == 0 || s_hi == 0 || s_lo == s_hi)
        begin
            res.root   = '0;
            res.status = 1'b1;
            return res;
        end
        mid = lo;
        hit = 1'b0;
        while (!hit && hi >= lo && hi - lo > tol)
        begin
            mid   = (lo + hi) >>> 1;
            s_mid = cubic_sign(mid);
            if (s_mid == 0)
            begin
                hit = 1'b1;
            end
            else if (s_mid != s_lo)
            begin
                hi = mid;
            end
            else
            begin
                lo = mid;
            end
        end
        res.root   = mid[31:0];
        res.status = 1'b0;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint exp_val);
        $display("checker: %s: got %0d, expected %0d at %0t", what, got, exp_val, $time);
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_roots.push_back(bisect_root(s_axis_tdata));
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_roots.size() == 0)
                begin
                    report_mismatch("result transaction with none pending",
                                    longint'(signed'(m_axis_tdata)), 0);
                end
                else
                begin
                    want = expected_roots.pop_front();
                    if (m_axis_tdata !== want.root)
                    begin
                        report_mismatch("root", longint'(signed'(m_axis_tdata)),
                                        longint'(signed'(want.root)));
                    end
                    if (m_axis_tuser !== want.status)
                    begin
                        report_mismatch("status", longint'(m_axis_tuser),
                                        longint'(want.status));
                    end
                end
            end
            roots_pending = expected_roots.size();
        end
    end

endmodule

/* tb/tb_cubic_bisection_root_finder_unit.sv */
// testbench top for the cubic bisection root finder: stimulus, flow control and verdict
`timescale 1ns / 1ps

module tb_cubic_bisection_root_finder_unit;

    localparam int     IN_W        =
        ((2 * cbrf_pkg::DATA_WIDTH_DEF + cbrf_pkg::TOL_WIDTH + 7) / 8) * 8;
    localparam int     OUT_W       = ((cbrf_pkg::DATA_WIDTH_DEF + 7) / 8) * 8;
    localparam int     CYCLE_LIMIT = 1000000;
    localparam int     PHASE_ITEMS = 500;
    localparam int     HOLD_CYCLES = 400;
    localparam longint ROOT_BELOW  = 137268;
    localparam longint ROOT_ABOVE  = 137269;
    localparam longint MAX_RAW     = 64'sd2147483647;
    localparam longint MIN_RAW     = -64'sd2147483648;
    localparam longint Q_ONE       = 65536;

    logic             clk            = 1'b0;
    logic             rst_n          = 1'b0;
    logic             s_axis_tvalid  = 1'b0;
    logic             s_axis_tready;
    logic [IN_W-1:0]  s_axis_tdata   = '0;
    logic             m_axis_tvalid;
    logic             m_axis_tready  = 1'b0;
    logic [OUT_W-1:0] m_axis_tdata;
    logic             m_axis_tuser;

    int   mismatch_count;
    int   roots_pending;
    int   cycle_count    = 0;
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    logic hold_off       = 1'b0;

    cubic_bisection_root_finder_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    cubic_bisection_root_finder_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tuser   (m_axis_tuser),
        .mismatch_count (mismatch_count),
        .roots_pending  (roots_pending)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("cubic_bisection_root_finder_unit: mismatch");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        m_axis_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic logic [IN_W-1:0] pack_item(input longint left_end, input longint right_end,
                                                   input longint tolerance);
        return {1'b0, tolerance[30:0], right_end[31:0], left_end[31:0]};
    endfunction

    function automatic longint random_span();
        int          bits;
        logic [31:0] r;
        bits = $urandom_range(0, 31);
        r    = $urandom;
        return (bits == 0) ? 0 : longint'(r >> (32 - bits));
    endfunction

    // mostly intervals that straddle the root, some reversed, the rest raw noise
    function automatic logic [IN_W-1:0] random_interval();
        longint left_end;
        longint right_end;
        longint tolerance;
        longint swap_tmp;
        int     pick;
        pick = $urandom_range(99);
        if (pick < 75)
        begin
            left_end  = ROOT_BELOW - random_span();
            right_end = ROOT_ABOVE + random_span();
            if (left_end < MIN_RAW)
            begin
                left_end = MIN_RAW;
            end
            if (right_end > MAX_RAW)
            begin
                right_end = MAX_RAW;
            end
            if ($urandom_range(99) < 5)
            begin
                swap_tmp  = left_end;
                left_end  = right_end;
                right_end = swap_tmp;
            end
        end
        else
        begin
            left_end  = longint'(signed'($urandom));
            right_end = longint'(signed'($urandom));
        end
        if ($urandom_range(99) < 80)
        begin
            tolerance = random_span();
        end
        else
        begin
            tolerance = longint'($urandom & 32'h7FFF_FFFF);
        end
        return pack_item(left_end, right_end, tolerance);
    endfunction

    // entered and left at a falling edge
    task automatic send_item(input logic [IN_W-1:0] item);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= {$urandom, $urandom, $urandom};
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= item;
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(negedge clk);
        while (roots_pending != 0)
        begin
            @(negedge clk);
        end
    endtask

    initial
    begin
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // extremes, zero tolerance, reversed interval, width within tolerance, no sign change
        send_item(pack_item(MIN_RAW, MAX_RAW, 1));
        send_item(pack_item(MIN_RAW, MAX_RAW, 0));
        send_item(pack_item(MIN_RAW, MAX_RAW, 64'h7FFF_FFFF));
        send_item(pack_item(MIN_RAW, MAX_RAW, Q_ONE));
        send_item(pack_item(3 * Q_ONE, 2 * Q_ONE, 1));
        send_item(pack_item(MAX_RAW, MIN_RAW, 0));
        send_item(pack_item(2 * Q_ONE, 3 * Q_ONE, Q_ONE));
        send_item(pack_item(2 * Q_ONE, 3 * Q_ONE, Q_ONE - 1));
        send_item(pack_item(2 * Q_ONE, 3 * Q_ONE, 1));
        send_item(pack_item(ROOT_BELOW, ROOT_ABOVE, 1));
        send_item(pack_item(ROOT_BELOW, ROOT_ABOVE, 0));
        send_item(pack_item(3 * Q_ONE, 10 * Q_ONE, 1));
        send_item(pack_item(MIN_RAW, 0, 1));
        send_item(pack_item(-1, 0, 1));
        send_item(pack_item(2 * Q_ONE, 2 * Q_ONE, 1));
        send_item(pack_item(0, MAX_RAW, 1));
        send_item(pack_item(ROOT_BELOW, MAX_RAW, 1));
        send_item(pack_item(MIN_RAW, ROOT_ABOVE, 1));
        send_item(pack_item(MAX_RAW, MAX_RAW, 64'h7FFF_FFFF));
        drain_results();

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct <= 0;
                    fork
                        begin
                            hold_off <= 1'b1;
                            repeat (HOLD_CYCLES) @(negedge clk);
                            hold_off <= 1'b0;
                        end
                    join_none
                end
                1:
                begin
                    send_idle_pct = 66;
                    recv_stall_pct <= 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct <= 66;
                end
                default:
                begin
                    send_idle_pct = 36;
                    recv_stall_pct <= 36;
                end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                send_item(random_interval());
            end
            drain_results();
        end

        repeat (60) @(negedge clk);
        if (mismatch_count == 0)
        begin
            $display("cubic_bisection_root_finder_unit: match");
        end
        else
        begin
            $display("cubic_bisection_root_finder_unit: mismatch");
        end
        $finish;
    end

endmodule
